@@ hdl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GOP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GOP_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GOP_ASSERT(label, clk, rst_n, prop, msg)
`define GOP_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ hdl/gop_pkg.sv @@
package gop_pkg;

    localparam int A_W     = 16;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 48;
    localparam int IDX_W   = 3;
    localparam int MAX_ROWS = 8;

    typedef struct packed {
        logic signed [A_W-1:0] a_elem0;
        logic signed [A_W-1:0] a_elem1;
        logic signed [A_W-1:0] a_elem2;
        logic signed [A_W-1:0] a_elem3;
        logic signed [A_W-1:0] a_elem4;
        logic signed [A_W-1:0] a_elem5;
        logic signed [A_W-1:0] a_elem6;
        logic signed [A_W-1:0] a_elem7;
        logic signed [A_W-1:0] b_value;
        logic [IDX_W-1:0]      b_column;
        logic                  end_of_product;
    } t_in_req;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_value;
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_column;
        logic                    last_result;
    } t_out_req;

    // per-lane control from the sequencer
    typedef struct packed {
        logic             mul_en;
        logic             acc_en;
        logic             clr_en;
        logic [IDX_W-1:0] col;
    } t_lane_ctl;

    // emit slot handed to the merge stage
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_emit;

endpackage

@@ hdl/gop_lane.sv @@
module gop_lane #(
    parameter int TILE_COLS = 6
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [gop_pkg::A_W-1:0]       i_a,
    input  logic signed [gop_pkg::A_W-1:0]       i_b,
    input  gop_pkg::t_lane_ctl                   i_ctl,
    output logic signed [gop_pkg::SUM_W-1:0]     o_sum
);

    localparam int COL_W = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
    localparam logic signed [gop_pkg::SUM_W-1:0] SAT_MAX = {1'b0, {(gop_pkg::SUM_W-1){1'b1}}};
    localparam logic signed [gop_pkg::SUM_W-1:0] SAT_MIN = {1'b1, {(gop_pkg::SUM_W-1){1'b0}}};

    logic signed [gop_pkg::PROD_W-1:0] r_prod;
    logic signed [gop_pkg::SUM_W-1:0]  r_acc [TILE_COLS];
    logic [COL_W-1:0]                  w_idx;
    logic signed [gop_pkg::SUM_W:0]    w_wide;
    logic signed [gop_pkg::SUM_W-1:0]  n_acc;

    assign w_idx = i_ctl.col[COL_W-1:0];
    assign o_sum = r_acc[w_idx];

    // saturating accumulate, one guard bit
    always_comb begin
        w_wide = {o_sum[gop_pkg::SUM_W-1], o_sum}
               + (gop_pkg::SUM_W+1)'(r_prod);
        if (w_wide[gop_pkg::SUM_W] != w_wide[gop_pkg::SUM_W-1]) begin
            n_acc = w_wide[gop_pkg::SUM_W] ? SAT_MIN : SAT_MAX;
        end else begin
            n_acc = w_wide[gop_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < TILE_COLS; c++) begin
                r_acc[c] <= '0;
            end
        end else if (i_ctl.acc_en) begin
            r_acc[w_idx] <= n_acc;
        end else if (i_ctl.clr_en) begin
            r_acc[w_idx] <= '0;
        end
    end

endmodule

@@ hdl/gop_merge.sv @@
module gop_merge #(
    parameter int TILE_ROWS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic signed [gop_pkg::SUM_W-1:0] i_lane_sum [TILE_ROWS],
    input  gop_pkg::t_emit                   i_emit,
    output logic                             o_valid,
    output gop_pkg::t_out_req                o_result
);

    localparam int ROW_W = $clog2(TILE_ROWS);

    logic              r_valid;
    gop_pkg::t_out_req r_out;
    gop_pkg::t_out_req n_out;

    always_comb begin
        n_out.sum_value   = i_lane_sum[i_emit.row[ROW_W-1:0]];
        n_out.out_row     = i_emit.row;
        n_out.out_column  = i_emit.col;
        n_out.last_result = i_emit.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

@@ hdl/gemm_outer_product_8x6.sv @@
// fixed-point outer-product accumulator for a TILE_ROWS x TILE_COLS tile of
// c = a*b. each request carries one a column, one b element and the c column
// it lands in; every row lane multiplies and adds its product into a 48-bit
// saturating accumulator. a request is taken on any clock edge with start
// high and busy low, so ordinary requests go in one per clock: the product
// is registered in each lane and added in the next cycle. a request with
// end_of_product set raises busy until its add has landed and the tile
// is fully drained: its own add lands first, then one result per cycle
// out of the merge register, column-major, row fastest. each result shows
// on o_result for exactly one cycle with o_valid high and cannot be held
// off; the receiver must take it then. the tile is cleared entry by entry
// as it is read, so the next product starts from zero. a column index at or
// above TILE_COLS adds nothing; the end flag on it still drains the tile.
`include "assert_macros.svh"

module gemm_outer_product_8x6 #(
    parameter int TILE_ROWS = 8,
    parameter int TILE_COLS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  gop_pkg::t_in_req   i_req,
    output logic               o_valid,
    output gop_pkg::t_out_req  o_result
);

    localparam int ROW_W = $clog2(TILE_ROWS);
    localparam int COL_W = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
    localparam logic [gop_pkg::IDX_W-1:0] COL_LIM  = gop_pkg::IDX_W'(TILE_COLS);
    localparam logic [ROW_W-1:0]          ROW_LAST = ROW_W'(TILE_ROWS - 1);
    localparam logic [COL_W-1:0]          COL_LAST = COL_W'(TILE_COLS - 1);

    // request acceptance
    logic w_accept;
    assign w_accept = start && !busy;

    // multiply stage bookkeeping
    logic                        r_p_acc;   // product stage holds an in-range item
    logic                        r_p_last;  // product stage holds the final item
    logic [gop_pkg::IDX_W-1:0]   r_p_col;

    // drain sequencer
    logic             r_emit;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             w_emit_last;

    assign w_emit_last = (r_row == ROW_LAST) && (r_col == COL_LAST);
    assign busy        = r_p_last || r_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_acc  <= 1'b0;
            r_p_last <= 1'b0;
        end else begin
            r_p_acc  <= w_accept && (i_req.b_column < COL_LIM);
            r_p_last <= w_accept && i_req.end_of_product;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_col <= i_req.b_column;
        end
    end

    // walk the tile column-major once the final add has landed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
            r_row  <= '0;
            r_col  <= '0;
        end else if (r_p_last) begin
            r_emit <= 1'b1;
            r_row  <= '0;
            r_col  <= '0;
        end else if (r_emit) begin
            if (r_row == ROW_LAST) begin
                r_row <= '0;
                if (r_col == COL_LAST) begin
                    r_emit <= 1'b0;
                    r_col  <= '0;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else begin
                r_row <= r_row + 1'b1;
            end
        end
    end

    // a column fanned out to the row lanes
    logic signed [gop_pkg::A_W-1:0]   w_a [gop_pkg::MAX_ROWS];
    logic signed [gop_pkg::SUM_W-1:0] w_lane_sum [TILE_ROWS];
    gop_pkg::t_lane_ctl               w_ctl [TILE_ROWS];

    assign w_a[0] = i_req.a_elem0;
    assign w_a[1] = i_req.a_elem1;
    assign w_a[2] = i_req.a_elem2;
    assign w_a[3] = i_req.a_elem3;
    assign w_a[4] = i_req.a_elem4;
    assign w_a[5] = i_req.a_elem5;
    assign w_a[6] = i_req.a_elem6;
    assign w_a[7] = i_req.a_elem7;

    for (genvar r = 0; r < TILE_ROWS; r++) begin : g_lane
        // accumulate and drain never overlap, so one column select serves both
        always_comb begin
            w_ctl[r].mul_en = w_accept;
            w_ctl[r].acc_en = r_p_acc;
            w_ctl[r].clr_en = r_emit && (r_row == ROW_W'(r));
            w_ctl[r].col    = r_emit ? gop_pkg::IDX_W'(r_col) : r_p_col;
        end

        gop_lane #(
            .TILE_COLS (TILE_COLS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_a     (w_a[r]),
            .i_b     (i_req.b_value),
            .i_ctl   (w_ctl[r]),
            .o_sum   (w_lane_sum[r])
        );
    end

    // merge: pick the lane for the current row and register the result
    gop_pkg::t_emit w_emit;

    always_comb begin
        w_emit.valid = r_emit;
        w_emit.row   = gop_pkg::IDX_W'(r_row);
        w_emit.col   = gop_pkg::IDX_W'(r_col);
        w_emit.last  = w_emit_last;
    end

    gop_merge #(
        .TILE_ROWS (TILE_ROWS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lane_sum (w_lane_sum),
        .i_emit     (w_emit),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    // checks
    `GOP_ASSERT(a_last_out, i_clk, i_rst_n, (r_emit && w_emit_last) |=> (o_valid && o_result.last_result), "final tile slot did not produce a last result")
    `GOP_ASSERT(a_last_done, i_clk, i_rst_n, (o_valid && o_result.last_result) |-> !r_emit, "drain still running after last result")
    `GOP_ASSERT(a_end_busy, i_clk, i_rst_n, (w_accept && i_req.end_of_product) |=> busy, "busy not raised after final request")
    `GOP_ASSERT(a_valid_src, i_clk, i_rst_n, o_valid |-> $past(r_emit), "result strobe without a drain slot")

endmodule
